@@ sv/wfgdd_pkg.sv @@
// shared types and constants for the wait-for graph deadlock detector
// no dependencies; compiled first

package wfgdd_pkg;

    localparam int unsigned AGENTS_DEFAULT = 4;

    // widths of the transaction fields
    localparam int unsigned OP_W  = 2;
    localparam int unsigned IDX_W = 2;

    // operation codes on the request channel
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // command kinds after classification by the front end
    localparam int unsigned KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // command queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // most transactions that can be inside the block at once:
    // queue entries, one in the back end, one in the output register
    localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  waiter;
        logic [IDX_W-1:0]  holder;
    } cmd_t;

endpackage

@@ sv/wfgdd_req_if.sv @@
// request channel: valid/ready handshake carrying one graph operation
// depends on wfgdd_pkg for the field widths

interface wfgdd_req_if;
    logic                           valid;
    logic                           ready;
    logic [wfgdd_pkg::OP_W-1:0]     operation;
    logic [wfgdd_pkg::IDX_W-1:0]    waiter;
    logic [wfgdd_pkg::IDX_W-1:0]    holder;

    modport source (output valid, output operation, output waiter, output holder,
                    input ready);
    modport sink   (input valid, input operation, input waiter, input holder,
                    output ready);
endinterface

@@ sv/wfgdd_rsp_if.sv @@
// response channel: valid/ready handshake carrying the deadlock flag
// no dependencies

interface wfgdd_rsp_if;
    logic valid;
    logic ready;
    logic deadlock;

    modport source (output valid, output deadlock, input ready);
    modport sink   (input valid, input deadlock, output ready);
endinterface

@@ sv/wfgdd_front.sv @@
// front end: accepts requests, range-checks and classifies them, queues commands
// depends on wfgdd_pkg and wfgdd_req_if

module wfgdd_front #(
    parameter int unsigned AGENTS = wfgdd_pkg::AGENTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    wfgdd_req_if.sink         req,
    output wfgdd_pkg::cmd_t   cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);

    localparam int unsigned PTR_W = (wfgdd_pkg::QUEUE_DEPTH > 1)
                                    ? $clog2(wfgdd_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(wfgdd_pkg::QUEUE_DEPTH + 1);

    wfgdd_pkg::cmd_t  queue_reg [wfgdd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    wfgdd_pkg::cmd_t  cls;
    logic             waiter_ok;
    logic             holder_ok;
    logic             push;

    assign waiter_ok = 32'(req.waiter) < 32'(AGENTS);
    assign holder_ok = 32'(req.holder) < 32'(AGENTS);

    // out-of-range agents and unknown codes become plain queries
    always_comb
    begin
        cls.waiter = req.waiter;
        cls.holder = req.holder;
        cls.kind   = wfgdd_pkg::KIND_NONE;
        case (req.operation)
            wfgdd_pkg::OP_ADD:
            begin
                if (waiter_ok && holder_ok)
                begin
                    cls.kind = wfgdd_pkg::KIND_ADD;
                end
            end
            wfgdd_pkg::OP_CLEAR:
            begin
                if (waiter_ok)
                begin
                    cls.kind = wfgdd_pkg::KIND_CLEAR;
                end
            end
            default:
            begin
                cls.kind = wfgdd_pkg::KIND_NONE;
            end
        endcase
    end

    assign req.ready = count_reg != CNT_W'(wfgdd_pkg::QUEUE_DEPTH);
    assign push      = req.valid && req.ready;
    assign cmd_valid = count_reg != '0;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(wfgdd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(wfgdd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ sv/wfgdd_back.sv @@
// back end: holds the wait-for matrix, runs the closure one pivot per cycle
// depends on wfgdd_pkg and wfgdd_rsp_if

module wfgdd_back #(
    parameter int unsigned AGENTS = wfgdd_pkg::AGENTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wfgdd_pkg::cmd_t   cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    wfgdd_rsp_if.source       rsp
);

    localparam int unsigned K_W = $clog2(AGENTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [AGENTS-1:0] matrix_reg [AGENTS];
    logic [AGENTS-1:0] matrix_next [AGENTS];
    logic [AGENTS-1:0] reach_reg [AGENTS];
    logic [AGENTS-1:0] reach_next [AGENTS];
    logic              out_valid_reg, out_valid_next;
    logic              out_deadlock_reg, out_deadlock_next;

    logic [AGENTS-1:0] holder_hot;
    logic              cycle_found;

    always_comb
    begin
        for (int unsigned j = 0; j < AGENTS; j++)
        begin
            holder_hot[j] = 32'(cmd.holder) == j;
        end
    end

    // a set diagonal bit in the closure is a cycle
    always_comb
    begin
        cycle_found = 1'b0;
        for (int unsigned i = 0; i < AGENTS; i++)
        begin
            cycle_found = cycle_found | reach_reg[i][i];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        matrix_next       = matrix_reg;
        reach_next        = reach_reg;
        cmd_pop           = 1'b0;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_deadlock_next = out_deadlock_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    for (int unsigned i = 0; i < AGENTS; i++)
                    begin
                        if (32'(cmd.waiter) == i)
                        begin
                            case (cmd.kind)
                                wfgdd_pkg::KIND_ADD:
                                begin
                                    matrix_next[i] = matrix_reg[i] | holder_hot;
                                end
                                wfgdd_pkg::KIND_CLEAR:
                                begin
                                    matrix_next[i] = '0;
                                end
                                default:
                                begin
                                    matrix_next[i] = matrix_reg[i];
                                end
                            endcase
                        end
                    end
                    reach_next = matrix_next;
                    k_next     = '0;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                // pivot k: every row that reaches k also reaches what k reaches
                for (int unsigned i = 0; i < AGENTS; i++)
                begin
                    if (reach_reg[i][k_reg])
                    begin
                        reach_next[i] = reach_reg[i] | reach_reg[k_reg];
                    end
                end
                if (k_reg == K_W'(AGENTS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_deadlock_next = cycle_found;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int unsigned i = 0; i < AGENTS; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            matrix_reg    <= matrix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reach_reg        <= reach_next;
        out_deadlock_reg <= out_deadlock_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.deadlock = out_deadlock_reg;

endmodule

@@ sv/wait_for_graph_deadlock_detector.sv @@
// Wait-for graph deadlock detector. Each request adds an edge waiter -> holder,
// clears all edges out of waiter, or only queries; every request returns one
// response telling whether the graph then holds a directed cycle (a self edge
// counts). Requests for agents at or above AGENTS, and unknown operation codes,
// leave the graph alone and act as queries. A request is queued in a
// QUEUE_DEPTH-entry command queue and is then handled in the back end, one
// request at a time: the matrix is updated, the transitive closure runs one
// pivot per cycle over all agents, and the response register is loaded once
// it is free. Requests are accepted while the queue has room, so up to
// four transactions can be in flight. The matrix is all zero after reset.
// depends on wfgdd_pkg, wfgdd_req_if, wfgdd_rsp_if, wfgdd_front, wfgdd_back

module wait_for_graph_deadlock_detector #(
    parameter int unsigned AGENTS = wfgdd_pkg::AGENTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    wfgdd_req_if.sink   req,
    wfgdd_rsp_if.source rsp
);

    wfgdd_pkg::cmd_t cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    wfgdd_front #(
        .AGENTS (AGENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    wfgdd_back #(
        .AGENTS (AGENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

@@ sv/wfgdd_checker.sv @@
// port-level checks for the deadlock detector, bound to the top level
// depends on wfgdd_pkg and wait_for_graph_deadlock_detector

module wfgdd_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_deadlock
);

    localparam int unsigned PEND_W = $clog2(wfgdd_pkg::MAX_PENDING + 1) + 1;

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              req_xfer;
    logic              rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (rsp_xfer && !req_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_deadlock))
        else $error("deadlock flag changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response without an outstanding request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(wfgdd_pkg::MAX_PENDING))
        else $error("more transactions in flight than the block can hold");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && pending_reg == '0 |=> !rsp_valid)
        else $error("response came too early for an idle block");

endmodule

bind wait_for_graph_deadlock_detector wfgdd_checker u_wfgdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_deadlock (rsp.deadlock)
);
